@@ sv/arx_counter_mode_stream_cipher_unit_defines.svh @@
// Assertion macros for the ARX counter-mode stream cipher unit.
// Used by the port checker; no other dependencies.
`ifndef ARX_COUNTER_MODE_STREAM_CIPHER_UNIT_DEFINES_SVH
`define ARX_COUNTER_MODE_STREAM_CIPHER_UNIT_DEFINES_SVH
// implication checked at every edge outside reset
`define ACS_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("ACS assertion failed");
// next-cycle implication
`define ACS_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("ACS assertion failed");
`endif

@@ sv/acs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and round functions of the stream cipher unit.
// No dependencies.
package acs_pkg;
  localparam int unsigned RoundPairsDefault = 10;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    REG_KEY_LOW      = 3'd0,
    REG_KEY_MID_LOW  = 3'd1,
    REG_KEY_MID_HIGH = 3'd2,
    REG_KEY_HIGH     = 3'd3,
    REG_NONCE_LOW    = 3'd4,
    REG_NONCE_HIGH   = 3'd5
  } reg_idx_t;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // one queued request: byte, its keystream position, a fresh-block flag
  // and the message start that restarts the counter
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       new_blk;
    logic       msg;
  } req_t;

  function automatic word_t rol(input word_t v, input int unsigned s);
    rol = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [127:0] qr(input word_t a, input word_t b,
                                      input word_t c, input word_t d);
    word_t aa, bb, cc, dd;
    aa = a + b; dd = rol(d ^ aa, 16);
    cc = c + dd; bb = rol(b ^ cc, 12);
    aa = aa + bb; dd = rol(dd ^ aa, 8);
    cc = cc + dd; bb = rol(bb ^ cc, 7);
    qr = {dd, cc, bb, aa};
  endfunction

  // half a double round: columns (diag=0) or diagonals (diag=1)
  function automatic state_t half_round(input state_t s, input logic diag);
    state_t o;
    logic [127:0] q;
    int unsigned b, c, d;
    o = s;
    for (int i = 0; i < 4; i++) begin
      b = diag ? 4 + ((i + 1) % 4) : 4 + i;
      c = diag ? 8 + ((i + 2) % 4) : 8 + i;
      d = diag ? 12 + ((i + 3) % 4) : 12 + i;
      q = qr(s[i], s[b], s[c], s[d]);
      o[i] = q[31:0]; o[b] = q[63:32]; o[c] = q[95:64]; o[d] = q[127:96];
    end
    half_round = o;
  endfunction

  function automatic word_t bswap(input word_t v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction
endpackage

@@ sv/acs_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks position and marks block starts.
// Depends on acs_pkg.
module acs_front import acs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_message_start,
  input  logic       q_full,
  output logic       q_push,
  output req_t       q_req
);
  logic [5:0] pos_r, pos_nxt;
  logic [5:0] cur_pos;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign cur_pos  = in_message_start ? 6'd0 : pos_r;
  assign pos_nxt  = cur_pos + 6'd1;
  assign q_req    = '{data: in_data_byte, pos: cur_pos,
                      new_blk: in_message_start || (pos_r == 6'd0),
                      msg: in_message_start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end
endmodule

@@ sv/acs_queue.sv @@
`timescale 1ns / 1ps
// Short request queue between front and back end.
// Depends on acs_pkg.
module acs_queue import acs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t din,
  output logic full,
  input  logic pop,
  output logic nempty,
  output req_t dout
);
  req_t ent_r [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QueueDepth):0] cnt_r;

  assign full   = cnt_r == ($clog2(QueueDepth)+1)'(QueueDepth);
  assign nempty = cnt_r != '0;
  assign dout   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QueueDepth){1'b0}}, push} -
               {{$clog2(QueueDepth){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end
endmodule

@@ sv/acs_back.sv @@
`timescale 1ns / 1ps
// Back end: key and nonce registers, 128-bit block counter, block sequencing
// and output register. Depends on acs_pkg and acs_core.
module acs_back import acs_pkg::*; #(
  parameter int unsigned ROUND_PAIRS = RoundPairsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        q_nempty,
  input  req_t        q_req,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_result_byte
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HAVE} st_t;

  logic [63:0] key_r [4];
  logic [63:0] nonce_r [2];
  logic [127:0] ctr_r, ctr_use;
  state_t init_w;
  logic [511:0] ks_w;
  st_t st_r;
  logic [7:0] res_r;
  logic ov_r, out_free, use_ok, start_blk, done_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_r[0] <= '0;
      nonce_r[1] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_LOW:      key_r[0] <= cfg_data;
        REG_KEY_MID_LOW:  key_r[1] <= cfg_data;
        REG_KEY_MID_HIGH: key_r[2] <= cfg_data;
        REG_KEY_HIGH:     key_r[3] <= cfg_data;
        REG_NONCE_LOW:    nonce_r[0] <= cfg_data;
        REG_NONCE_HIGH:   nonce_r[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ctr_r holds the counter of the next block; a message start restarts it
  assign ctr_use = q_req.msg ? '0 : ctr_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      init_w[i] = (i % 2 == 0) ? key_r[i/2][31:0] : key_r[i/2][63:32];
    end
    init_w[8]  = nonce_r[0][31:0];
    init_w[9]  = nonce_r[0][63:32];
    init_w[10] = nonce_r[1][31:0];
    init_w[11] = nonce_r[1][63:32];
    // big-endian counter read as little-endian words
    init_w[12] = bswap(ctr_use[127:96]);
    init_w[13] = bswap(ctr_use[95:64]);
    init_w[14] = bswap(ctr_use[63:32]);
    init_w[15] = bswap(ctr_use[31:0]);
  end

  assign out_free  = !ov_r || !out_stall;
  assign start_blk = q_nempty && q_req.new_blk && st_r == S_IDLE;
  // a block-start request is used once its block is ready
  assign use_ok    = q_nempty && out_free &&
                     (!q_req.new_blk || st_r == S_HAVE);
  assign q_pop     = use_ok;
  assign out_valid = ov_r;
  assign out_result_byte = res_r;

  acs_core #(.ROUND_PAIRS(ROUND_PAIRS)) u_core (.clk, .rst_n, .start(start_blk),
    .init_state(init_w), .done(done_blk), .ks(ks_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      ctr_r <= '0;
      res_r <= '0;
    end else begin
      if (out_free) ov_r <= use_ok;
      unique case (st_r)
        S_IDLE: if (start_blk) st_r <= S_RUN;
        S_RUN: if (done_blk) st_r <= S_HAVE;
        S_HAVE: if (use_ok) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (start_blk) ctr_r <= ctr_use + 128'd1;
      if (use_ok) res_r <= q_req.data ^ ks_w[8*q_req.pos +: 8];
    end
  end
endmodule

@@ sv/arx_counter_mode_stream_cipher_unit.sv @@
`timescale 1ns / 1ps
// Top level of the ARX counter-mode byte stream cipher.
// Depends on acs_pkg, acs_front, acs_queue, acs_back, acs_core.
//
// Usage: bytes enter on in_valid/in_stall with in_data_byte and
// in_message_start; each gives one out_result_byte on out_valid/out_stall.
// Key and nonce are written on cfg_valid/cfg_ready (always ready), index
// 0..5; the user must see that they are written only while the unit
// is idle, as the unit does not enforce this. out_valid is registered:
// a taken byte passes through the request queue and the output register.
// Within a block one byte per cycle while out_stall is low. The first byte
// of each 64-byte block waits for the block generator, which runs one half
// round per cycle; it starts the next block only once its first byte heads
// the request queue. Reset clears counter, position and keystream
// validity; key and nonce reset to zero. When the receiver stalls, the
// output register holds, the request queue fills and in_stall rises.
module arx_counter_mode_stream_cipher_unit import acs_pkg::*; #(
  parameter int unsigned ROUND_PAIRS = RoundPairsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_result_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic q_push, q_full, q_pop, q_nempty;
  req_t q_in, q_out;
  assign cfg_ready = 1'b1;

  acs_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_data_byte,
    .in_message_start, .q_full, .q_push, .q_req(q_in));
  acs_queue u_queue (.clk, .rst_n, .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .dout(q_out));
  acs_back #(.ROUND_PAIRS(ROUND_PAIRS)) u_back (.clk, .rst_n, .cfg_valid,
    .cfg_index, .cfg_data, .q_nempty, .q_req(q_out), .q_pop, .out_valid,
    .out_stall, .out_result_byte);
endmodule

@@ sv/acs_core.sv @@
`timescale 1ns / 1ps
// Block generator: one half round per cycle; keystream is the final
// round state XORed with the initial state. Depends on acs_pkg.
module acs_core import acs_pkg::*; #(
  parameter int unsigned ROUND_PAIRS = RoundPairsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  state_t       init_state,
  output logic         done,
  output logic [511:0] ks
);
  localparam int unsigned Halves = 2 * ROUND_PAIRS;
  localparam int unsigned CntW = $clog2(Halves + 1);

  state_t init_r, work_r;
  logic [CntW-1:0] rnd_r;
  logic run_r;

  assign done = run_r && rnd_r == CntW'(Halves);

  // round state is held after completion until the next start
  always_comb begin
    for (int i = 0; i < 16; i++) ks[32*i +: 32] = work_r[i] ^ init_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      rnd_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      rnd_r <= '0;
    end else if (run_r) begin
      if (done) run_r <= 1'b0;
      else rnd_r <= rnd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      init_r <= init_state;
      work_r <= init_state;
    end else if (run_r && !done) begin
      work_r <= half_round(work_r, rnd_r[0]);
    end
  end
endmodule

@@ sv/acs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the stream cipher unit, bound to the top level.
// Depends on the assertion macro header.
`include "arx_counter_mode_stream_cipher_unit_defines.svh"
module acs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_result_byte,
  input logic       cfg_ready
);
  `ACS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ACS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_result_byte))
  `ACS_ASSERT_IMP(a_cfg_rdy, clk, rst_n, 1'b1, cfg_ready)
  // a stalled request stays offered
  `ACS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
endmodule

bind arx_counter_mode_stream_cipher_unit acs_checker u_acs_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_result_byte, .cfg_ready);

@@ tb/sv/tb_arx_counter_mode_stream_cipher_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the ARX counter-mode byte stream cipher unit: directed and random byte
// requests, checked against a keystream predictor in a small scoreboard class.
// Depends on acs_pkg and arx_counter_mode_stream_cipher_unit.

class cipher_scoreboard;
  localparam int RoundPairs = 10;
  bit [63:0]  regs[6];
  bit [127:0] blk_ctr;
  bit [5:0]   pos;
  bit         ks_ready;
  bit [7:0]   ks[64];
  bit [31:0]  st[16];
  bit [7:0]   expected_bytes[$];
  int         mismatches;

  function new();
    foreach (regs[i]) regs[i] = '0;
    blk_ctr = '0;
    pos = '0;
    ks_ready = 0;
    mismatches = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [63:0] val);
    if (idx < 6) regs[idx] = val;   // indices 6 and 7 are ignored
  endfunction

  function bit [31:0] rotl(bit [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function void quarter(int a, int b, int c, int d);
    st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 16);
    st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 12);
    st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 8);
    st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 7);
  endfunction

  function void gen_keystream();
    bit [7:0] blk[64];
    for (int g = 0; g < 6; g++)
      for (int i = 0; i < 8; i++) blk[g * 8 + i] = regs[g][8 * i +: 8];
    // counter is big-endian in the last 16 bytes
    for (int i = 0; i < 16; i++) blk[48 + i] = blk_ctr[127 - 8 * i -: 8];
    for (int i = 0; i < 16; i++)
      st[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
    for (int r = 0; r < RoundPairs; r++) begin
      quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 64; i++) ks[i] = st[i >> 2][8 * (i & 3) +: 8] ^ blk[i];
  endfunction

  function void note_request(bit [7:0] data, bit msg_start);
    if (msg_start) begin
      blk_ctr = '0;
      pos = '0;
      ks_ready = 0;
    end
    if (!ks_ready) begin
      gen_keystream();
      ks_ready = 1;
    end
    expected_bytes.push_back(data ^ ks[pos]);
    pos++;
    if (pos == 0) begin
      blk_ctr++;
      ks_ready = 0;
    end
  endfunction

  function void check_result(bit [7:0] got);
    bit [7:0] want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result byte %02h", got);
      return;
    end
    want = expected_bytes.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("result byte: expected %02h, got %02h", want, got);
    end
  endfunction
endclass

module tb_arx_counter_mode_stream_cipher_unit;
  import acs_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles = 40;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_message_start = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_result_byte;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cipher_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  arx_counter_mode_stream_cipher_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_message_start,
    .out_valid, .out_stall, .out_result_byte, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver side, plus watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result_byte);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst_n || (out_valid && !out_stall) || (in_valid && !in_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input bit [7:0] data, input bit msg_start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= data;
    in_message_start <= msg_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(data, msg_start);
  endtask

  // registers only change once every request has drained
  task automatic write_reg(input bit [2:0] idx, input bit [63:0] val);
    in_valid <= 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == 0);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int phase_pct[4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{32, 32}};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero key, extremes of the data byte, message restart
    send_byte(8'h00, 1);
    send_byte(8'hFF, 0);
    send_byte(8'hA5, 1);
    send_byte(8'h5A, 0);
    for (int i = REG_KEY_LOW; i <= REG_NONCE_HIGH; i++) write_reg(3'(i), '1);
    write_reg(3'd6, rand64());   // unknown index, ignored
    write_reg(3'd7, '1);
    send_byte(8'hFF, 1);
    send_byte(8'h00, 0);
    // key change mid-block: old keystream stays until the next block
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    send_byte(8'h3C, 0);
    send_byte(8'hC3, 0);
    // spill past a block boundary to move the counter
    for (int i = 0; i < 66; i++) send_byte(8'($urandom_range(255)), 0);
    send_byte(8'h81, 1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      for (int r = 0; r < 3; r++) write_reg(3'($urandom_range(7)), rand64());
      for (int n = 0; n < 375;) begin
        int len;
        len = ($urandom_range(3) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 64);
        if ($urandom_range(9) == 0) begin
          // stream without a fresh start, continuing the current message
          for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 0);
        end else begin
          send_message(len);
        end
        n += len;
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid <= 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/acs_pkg.sv
sv/acs_front.sv
sv/acs_queue.sv
sv/acs_back.sv
sv/arx_counter_mode_stream_cipher_unit.sv
sv/acs_core.sv
sv/acs_checker.sv
tb/sv/tb_arx_counter_mode_stream_cipher_unit.sv
